// ----- rtl/ffba_pkg.sv -----
// ffba_pkg: shared types and constants of the first-fit block allocator
// fixed field widths, status codes, controller states, command and status structs
// no dependencies
package ffba_pkg;

  localparam int unsigned REQ_W      = 15;  // request_bytes field
  localparam int unsigned OFF_W      = 14;  // block_offset and result_offset fields
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned HDR_BYTES  = 8;   // header size, also the slot pitch
  localparam int unsigned HDR_SHIFT  = 3;   // log2 of the header size

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED    = 2'd0,
    ST_FREED        = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_NO_MEMORY    = 2'd3
  } ffba_status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_QUOT,
    S_NEED,
    S_WALK_RD,
    S_WALK_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } ffba_state_e;

  // controller to datapath
  typedef struct packed {
    logic         clear_wr;
    logic         load;
    logic         quot;
    logic         need;
    logic         rd_walk;
    logic         rd_free;
    logic         adv;
    logic         wr_take;
    logic         wr_end;
    logic         wr_free;
    logic         res_load;
    logic         res_at_pos;
    ffba_status_e res_status;
    logic         push;
  } ffba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic free_req;
    logic free_bad;
    logic walk_end;
    logic hdr_used;
    logic hdr_untouched;
    logic fits_end;
    logic fits_block;
    logic out_busy;
  } ffba_stat_t;

endpackage

// ----- rtl/ffba_if.sv -----
// ffba_if: request and response channel interfaces of the block allocator
// valid/ready handshake plus payload; depends on ffba_pkg for field widths
interface ffba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [ffba_pkg::REQ_W-1:0]  request_bytes;
  logic [ffba_pkg::OFF_W-1:0]  block_offset;

  modport source (output valid, mode, request_bytes, block_offset, input ready);
  modport sink   (input valid, mode, request_bytes, block_offset, output ready);
endinterface

interface ffba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffba_pkg::OFF_W-1:0]    result_offset;
  logic [ffba_pkg::STATUS_W-1:0] status;

  modport source (output valid, result_offset, status, input ready);
  modport sink   (input valid, result_offset, status, output ready);
endinterface

// ----- rtl/first_fit_block_allocator.sv -----
// first_fit_block_allocator: top level of the first-fit heap block allocator
// instantiates ffba_ctrl and ffba_dp; depends on ffba_pkg and ffba_if
//
// The allocator keeps one header per 8-byte slot of a HEAP_BYTES heap, each a used flag
// and a count of UNIT_BYTES units, in a single-port-style memory inside the datapath.
// After reset the header memory is cleared by a sweep over its HEAP_BYTES/8 headers (2048 at
// the defaults); requests are not taken during the sweep. An allocate beat rounds the
// byte count up to units (minimum one), then walks the headers from offset 0, taking the
// first free block that is big enough or the untouched end of the heap; it answers with
// the offset just past the header, or out of memory. A free beat clears the used flag of
// the header 8 bytes below its offset. One request is processed at a time: an allocate
// reads and then examines each header that it visits in turn, and a free reads its header
// and then checks it, or answers without a read when the offset cannot name a header. A
// finished result sits in an output register, so the next request is accepted while the
// previous result waits to be taken; a further finished result holds the sequencer until
// that register has been emptied.
module first_fit_block_allocator #(
  parameter int unsigned HEAP_BYTES = 16384,
  parameter int unsigned UNIT_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffba_req_if.sink   req_i,
  ffba_rsp_if.source rsp_o
);

  // command and status between sequencer and datapath
  ffba_pkg::ffba_cmd_t  cmd;
  ffba_pkg::ffba_stat_t stat;
  logic                 in_ready;

  // sequencer: clear sweep, rounding, header walk, free check, result push
  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // ready only while the sequencer is idle
  assign req_i.ready = in_ready;

  // datapath: header memory, walk pointer, rounding and output register
  ffba_dp #(
    .HEAP_BYTES (HEAP_BYTES),
    .UNIT_BYTES (UNIT_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (req_i.mode),
    .request_bytes_i (req_i.request_bytes),
    .block_offset_i  (req_i.block_offset),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .rsp_o           (rsp_o)
  );

endmodule

// ----- rtl/ffba_ctrl.sv -----
// ffba_ctrl: sequencing state machine of the block allocator
// drives ffba_cmd_t from ffba_stat_t; depends on ffba_pkg
module ffba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ffba_pkg::ffba_stat_t stat_i,
  output ffba_pkg::ffba_cmd_t  cmd_o
);

  ffba_pkg::ffba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffba_pkg::S_CLEAR: begin
        if (stat_i.clear_last) state_d = ffba_pkg::S_IDLE;
      end
      ffba_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ffba_pkg::S_QUOT;
      end
      ffba_pkg::S_QUOT: begin
        state_d = stat_i.free_req ? ffba_pkg::S_FREE_RD : ffba_pkg::S_NEED;
      end
      ffba_pkg::S_NEED: begin
        state_d = ffba_pkg::S_WALK_RD;
      end
      ffba_pkg::S_WALK_RD: begin
        state_d = stat_i.walk_end ? ffba_pkg::S_DONE : ffba_pkg::S_WALK_CHK;
      end
      ffba_pkg::S_WALK_CHK: begin
        if (!stat_i.hdr_used && (stat_i.hdr_untouched || stat_i.fits_block)) begin
          state_d = ffba_pkg::S_DONE;
        end else begin
          state_d = ffba_pkg::S_WALK_RD;
        end
      end
      ffba_pkg::S_FREE_RD: begin
        state_d = stat_i.free_bad ? ffba_pkg::S_DONE : ffba_pkg::S_FREE_CHK;
      end
      ffba_pkg::S_FREE_CHK: begin
        state_d = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_DONE: begin
        if (!stat_i.out_busy) state_d = ffba_pkg::S_IDLE;
      end
      default: state_d = ffba_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ffba_pkg::ST_ALLOCATED;
    in_ready_o       = 1'b0;
    unique case (state_q)
      ffba_pkg::S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
      end
      ffba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ffba_pkg::S_QUOT: begin
        cmd_o.quot = 1'b1;
      end
      ffba_pkg::S_NEED: begin
        cmd_o.need = 1'b1;
      end
      ffba_pkg::S_WALK_RD: begin
        if (stat_i.walk_end) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ffba_pkg::ST_NO_MEMORY;
        end else begin
          cmd_o.rd_walk = 1'b1;
        end
      end
      ffba_pkg::S_WALK_CHK: begin
        if (!stat_i.hdr_used && stat_i.hdr_untouched) begin
          cmd_o.res_load = 1'b1;
          if (stat_i.fits_end) begin
            cmd_o.wr_end     = 1'b1;
            cmd_o.res_at_pos = 1'b1;
            cmd_o.res_status = ffba_pkg::ST_ALLOCATED;
          end else begin
            cmd_o.res_status = ffba_pkg::ST_NO_MEMORY;
          end
        end else if (!stat_i.hdr_used && stat_i.fits_block) begin
          cmd_o.wr_take    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_at_pos = 1'b1;
          cmd_o.res_status = ffba_pkg::ST_ALLOCATED;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      ffba_pkg::S_FREE_RD: begin
        if (stat_i.free_bad) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ffba_pkg::ST_ALREADY_FREE;
        end else begin
          cmd_o.rd_free = 1'b1;
        end
      end
      ffba_pkg::S_FREE_CHK: begin
        cmd_o.res_load = 1'b1;
        if (stat_i.hdr_used) begin
          cmd_o.wr_free    = 1'b1;
          cmd_o.res_status = ffba_pkg::ST_FREED;
        end else begin
          cmd_o.res_status = ffba_pkg::ST_ALREADY_FREE;
        end
      end
      ffba_pkg::S_DONE: begin
        cmd_o.push = !stat_i.out_busy;
      end
      default: begin
        cmd_o.clear_wr = 1'b0;
      end
    endcase
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ffba_pkg::S_CLEAR |-> !in_ready_o)
    else $error("request taken during header clearing");

  a_load_starts_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ffba_pkg::S_QUOT)
    else $error("accepted beat did not start processing");

  a_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ffba_pkg::S_WALK_CHK |-> $past(cmd_o.rd_walk))
    else $error("header examined without a read");

endmodule

// ----- rtl/ffba_dp.sv -----
// ffba_dp: datapath of the block allocator: header memory, unit rounding,
// walk pointer, result and output registers; depends on ffba_pkg and ffba_rsp_if
module ffba_dp #(
  parameter int unsigned HEAP_BYTES = 16384,
  parameter int unsigned UNIT_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        mode_i,
  input  logic [ffba_pkg::REQ_W-1:0]  request_bytes_i,
  input  logic [ffba_pkg::OFF_W-1:0]  block_offset_i,
  input  ffba_pkg::ffba_cmd_t         cmd_i,
  output ffba_pkg::ffba_stat_t        stat_o,
  ffba_rsp_if.source                  rsp_o
);

  localparam int unsigned SLOTS   = HEAP_BYTES / ffba_pkg::HDR_BYTES;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W   = $clog2(HEAP_BYTES / UNIT_BYTES + 1);
  localparam int unsigned HDR_W   = CNT_W + 1;
  localparam int unsigned X_W     = ffba_pkg::REQ_W + 1;
  localparam int unsigned NEED_W  =
    $clog2(((1 << ffba_pkg::REQ_W) - 1 + UNIT_BYTES - 1) / UNIT_BYTES + 1);
  localparam int unsigned POS_W   = $clog2(HEAP_BYTES) + 3;
  localparam int unsigned SUM_W   = (POS_W > X_W ? POS_W : X_W) + 1;
  localparam int unsigned CMP_W   = (CNT_W > NEED_W ? CNT_W : NEED_W);
  localparam int unsigned FB_W    = (ffba_pkg::OFF_W > SLOT_W ? ffba_pkg::OFF_W : SLOT_W) + 1;
  localparam int unsigned RCP_SH  = 32;
  localparam int unsigned RCP_W   = 33;
  localparam int unsigned PROD_W  = X_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << RCP_SH) / UNIT_BYTES);

  // latched request
  logic                        mode_q;
  logic [ffba_pkg::REQ_W-1:0]  req_q;
  logic [ffba_pkg::OFF_W-1:0]  off_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      req_q  <= request_bytes_i;
      off_q  <= block_offset_i;
    end
  end

  // rounding to units: reciprocal estimate, then one correction step
  logic [X_W-1:0]    x;
  logic [PROD_W-1:0] prod;
  logic [NEED_W-1:0] q0_q;
  logic [X_W-1:0]    p;
  logic [X_W-1:0]    r;
  logic              corr;
  logic [NEED_W-1:0] need_c;
  logic [X_W-1:0]    nb_c;
  logic [NEED_W-1:0] need_q;
  logic [X_W-1:0]    nb_q;

  assign x    = X_W'(req_q) + X_W'(UNIT_BYTES - 1);
  assign prod = PROD_W'(x) * PROD_W'(RECIP);
  assign p    = X_W'(X_W'(q0_q) * X_W'(UNIT_BYTES));
  assign r    = x - p;
  assign corr = r >= X_W'(UNIT_BYTES);

  always_comb begin
    need_c = corr ? q0_q + NEED_W'(1) : q0_q;
    nb_c   = corr ? p + X_W'(UNIT_BYTES) : p;
    if (need_c == '0) begin
      need_c = NEED_W'(1);
      nb_c   = X_W'(UNIT_BYTES);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.quot) q0_q <= NEED_W'(prod >> RCP_SH);
    if (cmd_i.need) begin
      need_q <= need_c;
      nb_q   <= nb_c;
    end
  end

  // header memory and walk pointer
  logic [HDR_W-1:0]  mem_q [SLOTS];
  logic [HDR_W-1:0]  rdata_q;
  logic [SLOT_W-1:0] addr_q;
  logic [SLOT_W-1:0] clr_cnt_q;
  logic [POS_W-1:0]  pos_q;
  logic [SLOT_W-1:0] walk_slot;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] raddr;
  logic [SLOT_W-1:0] waddr;
  logic [HDR_W-1:0]  wdata;
  logic              we;
  logic              re;
  logic [CNT_W-1:0]  units;
  logic [FB_W-1:0]   off_hi;
  logic [POS_W-1:0]  pos_adv;

  assign units     = rdata_q[CNT_W-1:0];
  assign walk_slot = SLOT_W'(pos_q >> ffba_pkg::HDR_SHIFT);
  assign off_hi    = FB_W'(off_q >> ffba_pkg::HDR_SHIFT);
  assign free_slot = SLOT_W'(off_hi - FB_W'(1));
  assign raddr     = cmd_i.rd_walk ? walk_slot : free_slot;
  assign re        = cmd_i.rd_walk | cmd_i.rd_free;
  assign we        = cmd_i.clear_wr | cmd_i.wr_take | cmd_i.wr_end | cmd_i.wr_free;
  assign waddr     = cmd_i.clear_wr ? clr_cnt_q : addr_q;
  assign pos_adv   = pos_q + POS_W'(ffba_pkg::HDR_BYTES)
                   + POS_W'(POS_W'(units) * POS_W'(UNIT_BYTES));

  always_comb begin
    wdata = '0;
    if (cmd_i.wr_take) wdata = {1'b1, units};
    if (cmd_i.wr_end)  wdata = {1'b1, CNT_W'(need_q)};
    if (cmd_i.wr_free) wdata = {1'b0, units};
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (re) addr_q <= raddr;
    if (cmd_i.need) begin
      pos_q <= '0;
    end else if (cmd_i.adv) begin
      pos_q <= pos_adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
    end
  end

  // result and output registers
  logic [ffba_pkg::OFF_W-1:0] res_off_q;
  ffba_pkg::ffba_status_e     res_status_q;
  logic                       out_valid_q;
  logic [ffba_pkg::OFF_W-1:0] out_off_q;
  ffba_pkg::ffba_status_e     out_status_q;

  // status toward the controller
  always_comb begin
    stat_o.clear_last    = clr_cnt_q == SLOT_W'(SLOTS - 1);
    stat_o.free_req      = mode_q;
    stat_o.free_bad      = (off_hi == '0) || (off_q[ffba_pkg::HDR_SHIFT-1:0] != '0)
                         || (off_hi > FB_W'(SLOTS));
    stat_o.walk_end      = SUM_W'(pos_q) + SUM_W'(ffba_pkg::HDR_BYTES) > SUM_W'(HEAP_BYTES);
    stat_o.hdr_used      = rdata_q[HDR_W-1];
    stat_o.hdr_untouched = units == '0;
    stat_o.fits_end      = SUM_W'(pos_q) + SUM_W'(ffba_pkg::HDR_BYTES) + SUM_W'(nb_q)
                         <= SUM_W'(HEAP_BYTES);
    stat_o.fits_block    = CMP_W'(units) >= CMP_W'(need_q);
    stat_o.out_busy      = out_valid_q && !rsp_o.ready;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_off_q    <= cmd_i.res_at_pos
                    ? ffba_pkg::OFF_W'(pos_q + POS_W'(ffba_pkg::HDR_BYTES)) : '0;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.push) begin
      out_off_q    <= res_off_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_offset = out_off_q;
  assign rsp_o.status        = out_status_q;

  a_push_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !(out_valid_q && !rsp_o.ready))
    else $error("result overwritten before it was taken");

  a_walk_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_take || cmd_i.wr_end) |-> $past(cmd_i.rd_walk))
    else $error("header written without reading it first");

  a_zero_offset_unless_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ffba_pkg::ST_ALLOCATED |-> out_off_q == '0)
    else $error("nonzero offset on a non-allocation result");

endmodule
